// ===== hw/rtl/lrupr_pkg.sv =====
// lrupr_pkg: shared widths, constants and the reset value of the capacity register
// for the lru page replacement block; no dependencies
package lrupr_pkg;

	// fixed widths of the listing fields and of the capacity register
	localparam int OUT_PAGE_W = 16;
	localparam int POS_W      = 3;
	localparam int CFG_W      = 4;

	// capacity after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef logic [OUT_PAGE_W-1:0] out_page_t;
	typedef logic [POS_W-1:0]      pos_t;
	typedef logic [CFG_W-1:0]      cfg_data_t;

endpackage

// ===== hw/rtl/lrupr_ifs.sv =====
// lrupr channel interfaces: access items, listing results and capacity writes
// depends on lrupr_pkg for the fixed field widths
interface lrupr_acc_if #(
	parameter int PAGE_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

interface lrupr_res_if;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic                 fault_evicted;
	lrupr_pkg::out_page_t evicted_page;
	lrupr_pkg::pos_t      position;
	lrupr_pkg::out_page_t resident_page;
	logic                 last;

	modport source (output valid, output hit, output fault_evicted, output evicted_page,
		output position, output resident_page, output last, input ready);
	modport sink   (input valid, input hit, input fault_evicted, input evicted_page,
		input position, input resident_page, input last, output ready);
endinterface

interface lrupr_cfg_if;
	logic                 valid;
	logic                 ready;
	lrupr_pkg::cfg_data_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/lrupr_front.sv =====
// lrupr_front: accepts access items and holds them in a two-entry queue
// depends on lrupr_ifs (lrupr_acc_if)
module lrupr_front (
	input  logic         clk,
	input  logic         arst_n,
	lrupr_acc_if.sink    access,
	lrupr_acc_if.source  queue
);

	localparam int PAGE_BITS = $bits(access.page);

	logic [PAGE_BITS-1:0] slot_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push;
	logic                 pop;

	// handshakes on both sides
	assign access.ready = (fill_q != 2'd2);
	assign push         = access.valid && access.ready;
	assign queue.valid  = (fill_q != 2'd0);
	assign queue.page   = slot_q[rd_ptr_q];
	assign pop          = queue.valid && queue.ready;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= access.page;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/lrupr_back.sv =====
// lrupr_back: recency-ordered page list, lookup, update and listing sequencer
// depends on lrupr_pkg and lrupr_ifs
module lrupr_back #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lrupr_acc_if.sink    queue,
	lrupr_cfg_if.sink    cfg,
	lrupr_res_if.source  result
);

	localparam int CW   = $clog2(FRAMES + 1);
	localparam int CAPW = (CW > lrupr_pkg::CFG_W) ? CW : lrupr_pkg::CFG_W;
	localparam int OPW  = lrupr_pkg::OUT_PAGE_W;
	localparam int PW   = lrupr_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE,
		ST_LIST
	} state_t;

	state_t               state_q;
	lrupr_pkg::cfg_data_t fiu_q;

	// list entry 0 is the most recent page
	logic [PAGE_BITS-1:0] list_q [FRAMES];
	logic [PAGE_BITS-1:0] shift_src [FRAMES];
	logic [PAGE_BITS-1:0] rot_src [FRAMES];
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        pos_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [PAGE_BITS-1:0] tail_q;
	logic [FRAMES-1:0]    match_q;

	// outcome of the current access, held apart from a result still waiting
	logic                 upd_hit_q;
	logic                 upd_fault_q;
	lrupr_pkg::out_page_t upd_evict_q;

	// result register
	logic                 res_valid_q;
	logic                 hit_q;
	logic                 fault_q;
	lrupr_pkg::out_page_t evict_q;
	lrupr_pkg::pos_t      res_pos_q;
	lrupr_pkg::out_page_t res_page_q;
	logic                 res_last_q;

	logic [CAPW-1:0]      fiu_ext;
	logic [CAPW-1:0]      cap;
	logic                 free;
	logic                 any_hit;
	logic [CW-1:0]        hit_idx;
	logic [CW-1:0]        limit;
	logic                 emit;
	logic                 list_end;
	logic [CW+PW-1:0]     pos_wide;
	logic [PAGE_BITS+OPW-1:0] head_wide;
	logic [PAGE_BITS+OPW-1:0] tail_wide;

	// capacity clamped to one .. FRAMES
	always_comb begin
		fiu_ext = CAPW'(fiu_q);
		if (fiu_ext == '0) begin
			cap = CAPW'(1);
		end else if (fiu_ext > CAPW'(FRAMES)) begin
			cap = CAPW'(FRAMES);
		end else begin
			cap = fiu_ext;
		end
		free = CAPW'(count_q) < cap;
	end

	// hit position from the registered match vector
	always_comb begin
		any_hit = |match_q;
		hit_idx = '0;
		for (int k = 0; k < FRAMES; k++) begin
			if (match_q[k]) begin
				hit_idx = hit_idx | CW'(k);
			end
		end
		if (any_hit) begin
			limit = hit_idx;
		end else if (free) begin
			limit = count_q;
		end else begin
			limit = count_q - CW'(1);
		end
	end

	// neighbor taps for the insert shift and the listing rotation
	for (genvar g = 0; g < FRAMES; g++) begin : g_taps
		if (g == 0) begin : g_head
			assign shift_src[g] = page_q;
		end else begin : g_body
			assign shift_src[g] = list_q[g-1];
		end
		if (g == FRAMES - 1) begin : g_wrap
			assign rot_src[g] = list_q[0];
		end else begin : g_next
			assign rot_src[g] = list_q[g+1];
		end
	end

	// listing step control
	assign emit      = (state_q == ST_LIST) && (!res_valid_q || result.ready);
	assign list_end  = (pos_q == count_q - CW'(1));
	assign pos_wide  = (CW+PW)'(pos_q);
	assign head_wide = (PAGE_BITS+OPW)'(list_q[0]);
	assign tail_wide = (PAGE_BITS+OPW)'(tail_q);

	assign queue.ready = (state_q == ST_IDLE);
	assign cfg.ready   = 1'b1;

	// result port
	assign result.valid         = res_valid_q;
	assign result.hit           = hit_q;
	assign result.fault_evicted = fault_q;
	assign result.evicted_page  = evict_q;
	assign result.position      = res_pos_q;
	assign result.resident_page = res_page_q;
	assign result.last          = res_last_q;

	// page list, lookup and result payload
	always_ff @(posedge clk) begin
		if (queue.valid && queue.ready) begin
			page_q <= queue.page;
		end
		if (state_q == ST_LOOKUP) begin
			for (int k = 0; k < FRAMES; k++) begin
				match_q[k] <= (CW'(k) < count_q) && (list_q[k] == page_q);
			end
		end
		if (state_q == ST_UPDATE) begin
			// move the referenced page to the front
			for (int k = 0; k < FRAMES; k++) begin
				if (CW'(k) <= limit) begin
					list_q[k] <= shift_src[k];
				end
			end
			upd_hit_q   <= any_hit;
			upd_fault_q <= !any_hit && !free;
			upd_evict_q <= (!any_hit && !free) ? tail_wide[OPW-1:0] : '0;
		end
		if (emit) begin
			// rotate the occupied part so the next rank comes to the front
			for (int k = 0; k < FRAMES; k++) begin
				if (CW'(k) < count_q - CW'(1)) begin
					list_q[k] <= rot_src[k];
				end else if (CW'(k) == count_q - CW'(1)) begin
					list_q[k] <= list_q[0];
				end
			end
			hit_q      <= upd_hit_q;
			fault_q    <= upd_fault_q;
			evict_q    <= upd_evict_q;
			res_pos_q  <= pos_wide[PW-1:0];
			res_page_q <= head_wide[OPW-1:0];
			res_last_q <= list_end;
			if (list_end) begin
				tail_q <= list_q[0];
			end
		end
	end

	// sequencer, occupancy, capacity register and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			pos_q       <= '0;
			fiu_q       <= lrupr_pkg::CFG_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				fiu_q <= cfg.data;
			end
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (queue.valid) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (!any_hit && free) begin
						count_q <= count_q + CW'(1);
					end
					pos_q   <= '0;
					state_q <= ST_LIST;
				end
				ST_LIST: begin
					if (emit) begin
						pos_q <= pos_q + CW'(1);
						if (list_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// lru page replacement: an accepted item waits in the front queue, then the back takes it,
// looks it up and updates the list in its idle, lookup and update states before listing
// one page a cycle, stalled while a result waits unaccepted; the back takes no new item
// until its listing pass ends, which rotates the recency list one rank per listed page,
// while the front queue can hold two items meanwhile
// reset empties the frame set and sets the capacity to 8; no clearing pass
module lru_page_replacement #(
	parameter int FRAMES    = 8,
	parameter int PAGE_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	lrupr_acc_if.sink    access,
	lrupr_res_if.source  result,
	lrupr_cfg_if.sink    cfg
);

	// queue between the accepting front and the list sequencer
	lrupr_acc_if #(.PAGE_BITS(PAGE_BITS)) queue_ch ();

	lrupr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.access (access),
		.queue  (queue_ch.source)
	);

	lrupr_back #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.queue  (queue_ch.sink),
		.cfg    (cfg),
		.result (result)
	);

endmodule

// ===== tb/testbench.sv =====
// testbench for lru_page_replacement: random and directed page accesses under several
// frame capacities, with each listing item checked against a recency-list predictor
// depends on lrupr_pkg, the lrupr channel interfaces and the lru_page_replacement rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAMES     = 8;
	localparam int PAGE_BITS  = 16;
	localparam int CYCLE_CAP  = 200000;

	typedef logic [PAGE_BITS-1:0] page_t;

	// one listing item as the block should emit it
	typedef struct packed {
		logic                 hit;
		logic                 fault_evicted;
		lrupr_pkg::out_page_t evicted_page;
		lrupr_pkg::pos_t      position;
		lrupr_pkg::out_page_t resident_page;
		logic                 last;
	} listing_t;

	logic clk;
	logic arst_n;

	lrupr_acc_if #(.PAGE_BITS(PAGE_BITS)) acc_bus ();
	lrupr_res_if                          res_bus ();
	lrupr_cfg_if                          cfg_bus ();

	lru_page_replacement #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.access (acc_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	// pages waiting to be sent, and listing items still owed by the block
	page_t     access_queue[$];
	listing_t  expected_listing[$];

	// predictor state: resident pages ordered most recent first, plus capacity shadow
	page_t                recency_list[$];
	lrupr_pkg::cfg_data_t capacity_shadow;

	page_t     page_pool[16];
	bit        allow_idle;
	int        send_gap;
	int        stall_left;
	int        error_count;
	int        cycle_count;
	int        access_count;
	int        listing_count;
	int        hit_count;
	int        evict_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_error(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// append one page to the send queue
	task automatic queue_page(input page_t pg);
		access_queue.insert(access_queue.size(), pg);
	endtask

	// work out the listing that one accepted access produces
	task automatic predict_access(input page_t pg);
		int                   slot;
		int                   cap;
		logic                 was_hit;
		logic                 evicted;
		lrupr_pkg::out_page_t victim;
		listing_t             item;
		slot    = -1;
		cap     = (capacity_shadow == 0) ? 1 :
			(capacity_shadow > FRAMES) ? FRAMES : int'(capacity_shadow);
		evicted = 1'b0;
		victim  = '0;
		foreach (recency_list[i])
			if (slot < 0 && recency_list[i] == pg)
				slot = i;
		was_hit = (slot >= 0);
		if (was_hit) begin
			recency_list.delete(slot);
			hit_count++;
		end else if (recency_list.size() >= cap) begin
			// only the least recent page goes, even when capacity was lowered
			evicted = 1'b1;
			victim  = recency_list.pop_back();
			evict_count++;
		end
		recency_list.push_front(pg);
		access_count++;
		foreach (recency_list[p]) begin
			item.hit           = was_hit;
			item.fault_evicted = evicted;
			item.evicted_page  = victim;
			item.position      = lrupr_pkg::pos_t'(p);
			item.resident_page = recency_list[p];
			item.last          = (p == recency_list.size() - 1);
			expected_listing.insert(expected_listing.size(), item);
		end
	endtask

	task automatic check_field(input string name, input int idx, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_error($sformatf("listing item %0d field %s got %h expected %h",
				idx, name, got, want));
	endtask

	// access driver: sends queued pages, with random gaps after accepted items while idling is allowed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_bus.valid <= 1'b0;
			acc_bus.page  <= '0;
			send_gap      <= 0;
		end else begin
			if (acc_bus.valid && acc_bus.ready)
				predict_access(acc_bus.page);
			if (acc_bus.valid && !acc_bus.ready) begin
				// item still held, keep it steady
			end else if (send_gap != 0) begin
				acc_bus.valid <= 1'b0;
				send_gap      <= send_gap - 1;
			end else if (allow_idle && acc_bus.valid && $urandom_range(0, 4) == 0) begin
				acc_bus.valid <= 1'b0;
				send_gap      <= $urandom_range(0, 6);
			end else if (access_queue.size() != 0) begin
				acc_bus.valid <= 1'b1;
				acc_bus.page  <= access_queue.pop_front();
			end else begin
				acc_bus.valid <= 1'b0;
			end
		end
	end

	// listing monitor: random stall bursts on ready while idling is allowed, field by field compare
	always @(posedge clk or negedge arst_n) begin
		listing_t want;
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
			stall_left    <= 0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (expected_listing.size() == 0) begin
					report_error($sformatf("listing item %0d with nothing pending, page %h",
						listing_count, res_bus.resident_page));
				end else begin
					want = expected_listing.pop_front();
					check_field("hit", listing_count, res_bus.hit, want.hit);
					check_field("fault_evicted", listing_count, res_bus.fault_evicted,
						want.fault_evicted);
					check_field("evicted_page", listing_count, res_bus.evicted_page,
						want.evicted_page);
					check_field("position", listing_count, res_bus.position, want.position);
					check_field("resident_page", listing_count, res_bus.resident_page,
						want.resident_page);
					check_field("last", listing_count, res_bus.last, want.last);
				end
				listing_count++;
			end
			if (stall_left != 0) begin
				res_bus.ready <= 1'b0;
				stall_left    <= stall_left - 1;
			end else if (allow_idle && $urandom_range(0, 5) == 0) begin
				res_bus.ready <= 1'b0;
				stall_left    <= $urandom_range(0, 6);
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("timeout after %0d cycles, %0d listing items still owed",
				cycle_count, expected_listing.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// wait until the block has drained and sits idle
	task automatic wait_quiet();
		do
			@(negedge clk);
		while (access_queue.size() != 0 || acc_bus.valid || expected_listing.size() != 0);
		repeat (FRAMES + 3) @(negedge clk);
	endtask

	// capacity write through the config channel, only while idle
	task automatic write_capacity(input lrupr_pkg::cfg_data_t setting, input bit idle_on);
		wait_quiet();
		allow_idle = idle_on;
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= setting;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		cfg_bus.valid   <= 1'b0;
		capacity_shadow  = setting;
		@(negedge clk);
	endtask

	// random pages: mostly from a pool sized to give hits, sometimes any page
	task automatic random_accesses(input int count, input int span);
		repeat (count) begin
			if ($urandom_range(0, 7) == 0)
				queue_page(page_t'($urandom));
			else
				queue_page(page_pool[$urandom_range(0, span - 1)]);
		end
	endtask

	// stimulus and end of run
	initial begin
		arst_n          = 1'b0;
		acc_bus.valid   = 1'b0;
		acc_bus.page    = '0;
		res_bus.ready   = 1'b0;
		cfg_bus.valid   = 1'b0;
		cfg_bus.data    = '0;
		capacity_shadow = lrupr_pkg::CFG_RESET;
		allow_idle      = 1'b1;
		foreach (page_pool[i])
			page_pool[i] = page_t'($urandom);
		page_pool[0] = '0;
		page_pool[1] = '1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// capacity zero acts as one frame: every miss evicts once a page is resident
		write_capacity(4'd0, 1'b1);
		queue_page(16'h0000);
		queue_page(16'hFFFF);
		queue_page(16'hFFFF);
		queue_page(16'h8000);
		queue_page(16'h0001);
		random_accesses(10, 3);

		write_capacity(4'd1, 1'b1);
		random_accesses(10, 3);

		// three frames: fill, evict, hit on the least recent, evict, hit on the least recent again
		write_capacity(4'd3, 1'b1);
		queue_page(16'h0002);
		queue_page(16'h0003);
		queue_page(16'h0004);
		queue_page(16'h0002);
		queue_page(16'h0005);
		queue_page(16'h0004);
		random_accesses(25, 5);

		// capacity lowered below occupancy, no idling in this stretch
		write_capacity(4'd2, 1'b0);
		random_accesses(25, 5);

		// above the frame count acts as all frames
		write_capacity(4'd9, 1'b1);
		queue_page(16'hAAAA);
		queue_page(16'h5555);
		queue_page(16'h0000);
		queue_page(16'hFFFF);
		queue_page(16'h0010);
		queue_page(16'h0011);
		queue_page(16'h0012);
		queue_page(16'h0011);
		random_accesses(70, 11);

		write_capacity(4'd15, 1'b1);
		random_accesses(60, 12);

		write_capacity(4'd4, 1'b1);
		random_accesses(60, 10);

		// closing stretch at full capacity with neither side idling
		write_capacity(4'd8, 1'b0);
		random_accesses(70, 12);

		wait_quiet();
		$display("ran %0d accesses with %0d listing items: %0d hits, %0d evictions",
			access_count, listing_count, hit_count, evict_count);
		$display("capacity settings 0, 1, 3, 2, 9, 15, 4, 8, including lowering below occupancy");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
